/* rtl/stft_pkg.sv */
// ----------------------------------------------------------------------------
// stft_pkg: shared types and constants
// Table geometry, status codes, the entry layout and the controller states for
// the top level, and the compare result that it shares with the compare unit.
// ----------------------------------------------------------------------------
package stft_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int RANK_W      = 6;

  localparam logic [OCC_W-1:0]  OCC_FULL  = OCC_W'(TABLE_DEPTH);
  localparam logic [DATA_W-1:0] COUNT_MAX = '1;

  localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ENTRY   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd4;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DUMP   = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] term;
    logic [DATA_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

  typedef enum logic [2:0] {
    IDLE,
    S_PROBE,
    S_CMP,
    S_SHRD,
    S_SHWR,
    D_RD,
    D_PREV,
    D_BEST
  } state_t;

endpackage

/* rtl/sorted_term_frequency_table.sv */
// ----------------------------------------------------------------------------
// sorted_term_frequency_table: counted term table with sorted dump
// Holds up to 64 distinct signed terms with occurrence counts, kept sorted
// by term (largest first) in a single-port-read table memory.
// ----------------------------------------------------------------------------
// Usage: drive operation and term with start high while busy is low; the
// item is taken at that edge and busy rises the next cycle (an empty dump
// never raises it). Results appear on status, term_out, count_out, rank and
// last for one cycle with strobe high; the receiver cannot stall, so every
// strobe must be taken.
// An insert gives one result. It binary-searches the table, each probe a
// memory read, then a compare in the shared comparator, with at most
// seven probes plus one closing check. A new term then moves each lower
// entry down one slot (a read, then a write) and is then placed, and the
// result is strobed as busy falls; a hit or a drop skips the move.
// A dump gives one result per stored entry in count order; each result
// takes a full selection pass over the stored entries. An empty dump
// answers in the cycle after the item is taken. Reset clears occupancy.
// ----------------------------------------------------------------------------
module sorted_term_frequency_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic signed [stft_pkg::DATA_W-1:0] term,
  output logic                          strobe,
  output logic [stft_pkg::STATUS_W-1:0] status,
  output logic signed [stft_pkg::DATA_W-1:0] term_out,
  output logic [stft_pkg::DATA_W-1:0]   count_out,
  output logic [stft_pkg::RANK_W-1:0]   rank,
  output logic                          last
);
  import stft_pkg::*;

  state_t state, state_next;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;

  logic [OCC_W-1:0]  occ;
  logic [OCC_W-1:0]  lo;
  logic [OCC_W-1:0]  hi;
  logic [OCC_W-1:0]  sh;
  logic [ADDR_W-1:0] mid;
  logic [DATA_W-1:0] key;

  logic [ADDR_W-1:0] scan;
  logic [OCC_W-1:0]  k;
  logic              first;
  logic              cand;
  logic              best_valid;
  logic [DATA_W-1:0] best_cnt;
  logic [DATA_W-1:0] best_term;
  logic [ADDR_W-1:0] best_idx;
  logic [DATA_W-1:0] prev_cnt;
  logic [ADDR_W-1:0] prev_idx;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic [DATA_W-1:0]   emit_term;
  logic [DATA_W-1:0]   emit_count;
  logic [RANK_W-1:0]   emit_rank;
  logic                emit_last;

  logic [DATA_W-1:0] cmp_a;
  logic [DATA_W-1:0] cmp_b;
  logic              cmp_signed;
  cmp_t              cmp_res;

  logic [OCC_W-1:0]  mid_w;
  logic [DATA_W-1:0] sat_inc;
  logic              scan_end;
  logic              k_end;
  logic              take;
  logic              better;
  logic              cand_w;

  stft_cmp u_cmp (
    .a         (cmp_a),
    .b         (cmp_b),
    .is_signed (cmp_signed),
    .res       (cmp_res)
  );

  assign busy = (state != IDLE);
  assign take = start && !busy;

  always_comb begin
    mid_w    = OCC_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
    sat_inc  = (rd_data.count == COUNT_MAX) ? rd_data.count : rd_data.count + 1'b1;
    scan_end = ({1'b0, scan} == occ - 1'b1);
    k_end    = (k == occ - 1'b1);
  end

  // comparator input select
  always_comb begin
    case (state)
      S_CMP: begin
        cmp_a      = rd_data.term;
        cmp_b      = key;
        cmp_signed = 1'b1;
      end
      D_PREV: begin
        cmp_a      = rd_data.count;
        cmp_b      = prev_cnt;
        cmp_signed = 1'b0;
      end
      default: begin
        cmp_a      = rd_data.count;
        cmp_b      = best_cnt;
        cmp_signed = 1'b0;
      end
    endcase
  end

  // an entry is still to come if it orders after the last one emitted
  assign cand_w = first || (!cmp_res.gt && !cmp_res.eq) ||
                  (cmp_res.eq && (scan > prev_idx));
  assign better = cand && (!best_valid || cmp_res.gt);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (take) begin
          if (operation == OP_INSERT) begin
            state_next = S_PROBE;
          end else if (occ != '0) begin
            state_next = D_RD;
          end
        end
      end
      S_PROBE: begin
        if (lo < hi) begin
          state_next = S_CMP;
        end else if (occ == OCC_FULL) begin
          state_next = IDLE;
        end else begin
          state_next = S_SHRD;
        end
      end
      S_CMP: begin
        state_next = cmp_res.eq ? IDLE : S_PROBE;
      end
      S_SHRD: begin
        state_next = (sh > lo) ? S_SHWR : IDLE;
      end
      S_SHWR: begin
        state_next = S_SHRD;
      end
      D_RD: begin
        state_next = D_PREV;
      end
      D_PREV: begin
        state_next = D_BEST;
      end
      D_BEST: begin
        if (!scan_end) begin
          state_next = D_RD;
        end else if (k_end) begin
          state_next = IDLE;
        end else begin
          state_next = D_RD;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // memory control and result values
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = mid_w[ADDR_W-1:0];
    wr_en       = 1'b0;
    wr_addr     = sh[ADDR_W-1:0];
    wr_data     = rd_data;
    emit        = 1'b0;
    emit_status = ST_COUNTED;
    emit_term   = key;
    emit_count  = '0;
    emit_rank   = '0;
    emit_last   = 1'b1;
    case (state)
      IDLE: begin
        if (take && operation == OP_DUMP && occ == '0) begin
          emit        = 1'b1;
          emit_status = ST_EMPTY;
          emit_term   = '0;
        end
      end
      S_PROBE: begin
        if (lo < hi) begin
          rd_en = 1'b1;
        end else if (occ == OCC_FULL) begin
          emit        = 1'b1;
          emit_status = ST_DROPPED;
        end
      end
      S_CMP: begin
        if (cmp_res.eq) begin
          wr_en         = 1'b1;
          wr_addr       = mid;
          wr_data.term  = rd_data.term;
          wr_data.count = sat_inc;
          emit          = 1'b1;
          emit_status   = ST_COUNTED;
          emit_count    = sat_inc;
        end
      end
      S_SHRD: begin
        if (sh > lo) begin
          rd_en   = 1'b1;
          rd_addr = ADDR_W'(sh - 1'b1);
        end else begin
          // slot is open: place the new term
          wr_en         = 1'b1;
          wr_addr       = lo[ADDR_W-1:0];
          wr_data.term  = key;
          wr_data.count = DATA_W'(1);
          emit          = 1'b1;
          emit_status   = ST_ADDED;
          emit_count    = DATA_W'(1);
        end
      end
      S_SHWR: begin
        wr_en = 1'b1;
      end
      D_RD: begin
        rd_en   = 1'b1;
        rd_addr = scan;
      end
      D_BEST: begin
        if (scan_end) begin
          emit        = 1'b1;
          emit_status = ST_ENTRY;
          emit_term   = better ? rd_data.term : best_term;
          emit_count  = better ? rd_data.count : best_cnt;
          emit_rank   = RANK_W'(k);
          emit_last   = k_end;
        end
      end
      default: ;
    endcase
  end

  // table memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      occ    <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (state == S_SHRD && !(sh > lo)) begin
        occ <= occ + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (emit) begin
      status    <= emit_status;
      term_out  <= emit_term;
      count_out <= emit_count;
      rank      <= emit_rank;
      last      <= emit_last;
    end
  end

  // search, move and selection registers
  always_ff @(posedge clk) begin
    case (state)
      IDLE: begin
        if (take) begin
          key        <= term;
          lo         <= '0;
          hi         <= occ;
          sh         <= occ;
          scan       <= '0;
          k          <= '0;
          first      <= 1'b1;
          best_valid <= 1'b0;
        end
      end
      S_PROBE: begin
        mid <= mid_w[ADDR_W-1:0];
      end
      S_CMP: begin
        if (!cmp_res.eq) begin
          if (cmp_res.gt) begin
            lo <= {1'b0, mid} + 1'b1;
          end else begin
            hi <= {1'b0, mid};
          end
        end
      end
      S_SHWR: begin
        sh <= sh - 1'b1;
      end
      D_PREV: begin
        cand <= cand_w;
      end
      D_BEST: begin
        if (scan_end) begin
          // hand the winner over as the new bound and restart the pass
          prev_cnt   <= better ? rd_data.count : best_cnt;
          prev_idx   <= better ? scan : best_idx;
          first      <= 1'b0;
          best_valid <= 1'b0;
          scan       <= '0;
          k          <= k + 1'b1;
        end else begin
          if (better) begin
            best_valid <= 1'b1;
            best_cnt   <= rd_data.count;
            best_term  <= rd_data.term;
            best_idx   <= scan;
          end
          scan <= scan + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/stft_cmp.sv */
// ----------------------------------------------------------------------------
// stft_cmp: shared magnitude comparator
// Compares two 32-bit words as signed or unsigned values; gives a == b and
// a > b. Used for term probes during search and count checks during dump.
// ----------------------------------------------------------------------------
module stft_cmp (
  input  logic [stft_pkg::DATA_W-1:0] a,
  input  logic [stft_pkg::DATA_W-1:0] b,
  input  logic                        is_signed,
  output stft_pkg::cmp_t              res
);
  import stft_pkg::*;

  logic [DATA_W-1:0] a_adj;
  logic [DATA_W-1:0] b_adj;

  // flip the sign bits so a signed compare becomes an unsigned one
  always_comb begin
    a_adj = a ^ {is_signed, {(DATA_W-1){1'b0}}};
    b_adj = b ^ {is_signed, {(DATA_W-1){1'b0}}};
    res.eq = (a == b);
    res.gt = (a_adj > b_adj);
  end

endmodule
